@@ src/bhp_pkg.sv @@
package bhp_pkg;

	localparam int WINDOW_BYTES = 512;
	localparam int CHIP_NAMES = 3;
	localparam int OFF_W = 17;

	localparam logic [OFF_W-1:0] OFF_WINDOW = OFF_W'(WINDOW_BYTES);
	localparam logic [OFF_W-1:0] OFF_HDR_LIMIT = OFF_W'(WINDOW_BYTES - 1);
	localparam logic [OFF_W-1:0] OFF_WALK_LIMIT = OFF_W'(WINDOW_BYTES - 3);
	localparam logic [OFF_W-1:0] OFF_ETAG_LAST = OFF_W'(WINDOW_BYTES - 7);

	localparam logic [7:0] BYTE_RAW = 8'hFF;
	localparam logic [7:0] TAG_E = 8'h65;
	localparam logic [7:0] TAG_B = 8'h62;
	localparam logic [15:0] VERSION_OK = 16'h0001;
	localparam logic [31:0] LEN_UNKNOWN = 32'hFFFF_FFFF;

	localparam logic [2:0] POS_END = 3'd6;
	localparam logic [2:0] POS_IDLE = 3'd7;
	localparam logic [1:0] CHIP_NONE = 2'd3;
	localparam logic [CHIP_NAMES-1:0] FLAGS_ALL = {CHIP_NAMES{1'b1}};

	localparam logic [7:0] DEV_NAMES [0:2][0:5] = '{
		'{8'h37, 8'h61, 8'h33, 8'h35, 8'h74, 8'h00},
		'{8'h37, 8'h61, 8'h31, 8'h30, 8'h30, 8'h74},
		'{8'h37, 8'h61, 8'h32, 8'h30, 8'h30, 8'h74}
	};
	localparam logic [2:0] DEV_LAST [0:2] = '{3'd4, 3'd5, 3'd5};

	typedef enum logic [1:0] {
		STAT_LENGTH  = 2'd0,
		STAT_RAW     = 2'd1,
		STAT_BAD_VER = 2'd2,
		STAT_NO_LEN  = 2'd3
	} status_t;

	typedef enum logic [10:0] {
		PH_HDR0 = 11'b000_0000_0001,
		PH_HDR1 = 11'b000_0000_0010,
		PH_SKIP = 11'b000_0000_0100,
		PH_VER0 = 11'b000_0000_1000,
		PH_VER1 = 11'b000_0001_0000,
		PH_TAG  = 11'b000_0010_0000,
		PH_ELEN = 11'b000_0100_0000,
		PH_LEN0 = 11'b000_1000_0000,
		PH_LEN1 = 11'b001_0000_0000,
		PH_OVER = 11'b010_0000_0000,
		PH_DONE = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] total_length;
		logic [1:0]  chip_type;
	} out_item_t;

	typedef struct packed {
		logic                  valid;
		out_item_t             item;
	} step_res_t;

	typedef struct packed {
		logic [2:0]            pos;
		logic [CHIP_NAMES-1:0] flags;
		logic [1:0]            found;
	} match_t;

endpackage

@@ src/bhp_name_match.sv @@
module bhp_name_match (
	input  logic [7:0]      data_byte,
	input  bhp_pkg::match_t cur,
	output bhp_pkg::match_t nxt
);
	import bhp_pkg::*;

	always_comb begin
		nxt = cur;
		if (cur.pos < POS_END) begin
			for (int q = 0; q < CHIP_NAMES; q++) begin
				if (cur.flags[q]) begin
					if (data_byte != DEV_NAMES[q][cur.pos]) begin
						nxt.flags[q] = 1'b0;
					end else if (cur.pos == DEV_LAST[q]) begin
						nxt.found = 2'(q);
						nxt.flags[q] = 1'b0;
					end
				end
			end
			nxt.pos = cur.pos + 3'd1;
			if (nxt.pos >= POS_END || nxt.flags == '0) begin
				nxt.pos = POS_IDLE;
			end
		end
	end

endmodule

@@ src/bhp_parse_core.sv @@
module bhp_parse_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  bhp_pkg::in_item_t  item,
	input  logic [31:0]        file_size,
	output bhp_pkg::step_res_t res
);
	import bhp_pkg::*;

	logic [OFF_W-1:0] off_q, nfo_q, ts_q;
	phase_t           ph_q;
	logic [7:0]       tag_q;
	logic [31:0]      acc_q;
	match_t           match_q;

	logic [OFF_W-1:0] w_off, w_nfo, w_ts, n_off, n_nfo, n_ts, p, nxt_off;
	phase_t           w_ph, n_ph;
	logic [7:0]       w_tag, n_tag, b;
	logic [31:0]      w_acc, n_acc, acc_sh;
	match_t           w_match, m_match, n_match;
	logic             in_win, hit, emit;
	status_t          stat;
	logic [31:0]      len;

	assign b = item.data_byte;

	bhp_name_match u_match (
		.data_byte(b),
		.cur      (w_match),
		.nxt      (m_match)
	);

	always_comb begin
		if (item.first) begin
			w_off = '0;
			w_nfo = '0;
			w_ts = '0;
			w_ph = PH_HDR0;
			w_tag = '0;
			w_acc = '0;
			w_match = '{pos: POS_IDLE, flags: '0, found: CHIP_NONE};
		end else begin
			w_off = off_q;
			w_nfo = nfo_q;
			w_ts = ts_q;
			w_ph = ph_q;
			w_tag = tag_q;
			w_acc = acc_q;
			w_match = match_q;
		end

		n_off = w_off;
		n_nfo = w_nfo;
		n_ts = w_ts;
		n_ph = w_ph;
		n_tag = w_tag;
		n_acc = w_acc;
		n_match = w_match;
		emit = 1'b0;
		stat = STAT_LENGTH;
		len = '0;
		nxt_off = '0;
		acc_sh = {w_acc[23:0], b};
		p = w_off;
		in_win = p < OFF_WINDOW;
		hit = (w_ph == PH_SKIP || w_ph == PH_TAG) && p == w_nfo;

		if (w_ph != PH_DONE) begin
			if (in_win) begin
				n_match = m_match;
				unique case (w_ph)
					PH_HDR0: begin
						n_acc = {24'b0, b};
						n_ph = PH_HDR1;
					end
					PH_HDR1: begin
						if (w_acc == {24'b0, BYTE_RAW} && b == BYTE_RAW) begin
							emit = 1'b1;
							stat = STAT_RAW;
							len = (file_size == '0) ? LEN_UNKNOWN : file_size;
						end else begin
							nxt_off = OFF_W'({w_acc[7:0], b}) + OFF_W'(2);
							n_nfo = nxt_off;
							if (nxt_off >= OFF_HDR_LIMIT) begin
								emit = 1'b1;
								stat = STAT_BAD_VER;
							end else begin
								n_ph = PH_SKIP;
							end
						end
					end
					PH_SKIP: begin
						if (hit) begin
							n_acc = {24'b0, b};
							n_ph = PH_VER1;
						end
					end
					PH_VER0: begin
						n_acc = {24'b0, b};
						n_ph = PH_VER1;
					end
					PH_VER1: begin
						if (acc_sh != {16'b0, VERSION_OK}) begin
							emit = 1'b1;
							stat = STAT_BAD_VER;
						end else begin
							nxt_off = p + OFF_W'(1);
							n_nfo = nxt_off;
							n_ph = (nxt_off >= OFF_WALK_LIMIT) ? PH_OVER : PH_TAG;
						end
					end
					PH_TAG: begin
						if (hit) begin
							n_tag = b;
							n_ts = p;
							n_acc = '0;
							if (b == TAG_E) begin
								n_ph = (p <= OFF_ETAG_LAST) ? PH_ELEN : PH_OVER;
							end else begin
								n_ph = PH_LEN0;
							end
						end
					end
					PH_ELEN: begin
						n_acc = acc_sh;
						if (p == w_ts + OFF_W'(4)) begin
							emit = 1'b1;
							stat = STAT_LENGTH;
							len = acc_sh + 32'(w_ts) + 32'd5;
						end
					end
					PH_LEN0: begin
						n_acc = {24'b0, b};
						n_ph = PH_LEN1;
					end
					PH_LEN1: begin
						if (w_tag == TAG_B) begin
							n_match.pos = '0;
							n_match.flags = FLAGS_ALL;
						end
						nxt_off = w_ts + OFF_W'({w_acc[7:0], b}) + OFF_W'(3);
						n_nfo = nxt_off;
						n_ph = (nxt_off >= OFF_WALK_LIMIT) ? PH_OVER : PH_TAG;
					end
					default: begin
					end
				endcase
				if (!emit) begin
					n_off = p + OFF_W'(1);
				end
			end

			if (!emit) begin
				if (n_ph == PH_OVER && n_match.pos == POS_IDLE) begin
					emit = 1'b1;
					stat = STAT_NO_LEN;
				end else if (item.final_byte || p + OFF_W'(1) >= OFF_WINDOW) begin
					emit = 1'b1;
					if (n_ph == PH_HDR0 || n_ph == PH_HDR1 || n_ph == PH_SKIP ||
					    n_ph == PH_VER0 || n_ph == PH_VER1) begin
						stat = STAT_BAD_VER;
					end else begin
						stat = STAT_NO_LEN;
					end
					n_match.pos = POS_IDLE;
					n_match.flags = '0;
				end
			end
			if (emit) begin
				n_ph = PH_DONE;
			end
		end

		res.valid = emit;
		res.item.status = stat;
		res.item.total_length = len;
		res.item.chip_type = n_match.found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			nfo_q <= '0;
			ts_q <= '0;
			ph_q <= PH_HDR0;
			tag_q <= '0;
			acc_q <= '0;
			match_q <= '{pos: POS_IDLE, flags: '0, found: CHIP_NONE};
		end else if (step_en) begin
			off_q <= n_off;
			nfo_q <= n_nfo;
			ts_q <= n_ts;
			ph_q <= n_ph;
			tag_q <= n_tag;
			acc_q <= n_acc;
			match_q <= n_match;
		end
	end

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.valid |=> ph_q == PH_DONE)
		else $error("parse did not close after a result");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_DONE && !item.first |-> !res.valid)
		else $error("second result for one file");

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		off_q <= OFF_WINDOW)
		else $error("byte offset ran past the window");

	a_match_pos: assert property (@(posedge clk) disable iff (!arst_n)
		match_q.pos != POS_END)
		else $error("name match position left at end marker");

endmodule

@@ src/bitstream_header_parser.sv @@
// Parses the header of an FPGA configuration file fed one byte per item and
// returns one result per file: the status, the total length and the matched
// device. Mark the first byte of each file with first; mark the last byte
// available with final_byte to force a result. Only the first 512 bytes are
// examined, and bytes after the result are dropped until the next first.
// The block takes one byte every cycle while in_stall is low; the parse step
// for a byte is combinational between the input register and the result
// register, so a result is registered as its byte leaves the input register
// and is held in the result register until it is taken. in_stall rises only
// while a byte waits in the input register and the result register holds a
// result that is stalled. Write file_size only while no byte is in flight.
module bitstream_header_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  bhp_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output bhp_pkg::out_item_t out_data
);
	import bhp_pkg::*;

	logic        file_size_q;
	logic [31:0] file_size_val_q;
	logic        valid_s1;
	in_item_t    item_s1;
	logic        res_valid_s2;
	out_item_t   res_item_s2;
	logic        advance;
	step_res_t   res;

	assign advance = valid_s1 && (!res_valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign out_valid = res_valid_s2;
	assign out_data = res_item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q <= 1'b0;
			file_size_val_q <= '0;
		end else if (cfg_wr_en) begin
			file_size_q <= 1'b1;
			file_size_val_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	bhp_parse_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (advance),
		.item     (item_s1),
		.file_size(file_size_q ? file_size_val_q : 32'd0),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance && res.valid) begin
			res_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			res_item_s2 <= res.item;
		end
	end

endmodule
